// ===== src/hslrgb_pkg.sv =====
// hslrgb_pkg: shared widths and constants for the HSL to RGB converter.
// Used by hslrgb_chan and hsl_to_rgb_converter_top; no dependencies.
`default_nettype none

package hslrgb_pkg;

	localparam int CHANNEL_BITS_DEF = 8;

	localparam int HUE_W  = 9;
	localparam int SL_W   = 8;
	localparam int LVL_W  = 16;
	localparam int NUM_W  = 22;
	localparam int RAMP_W = 6;

	localparam int CHAN_STAGES = 4;

	localparam int HUE_FULL  = 360;
	localparam int HUE_THIRD = 120;
	localparam int SIXTH_DEG = 60;
	localparam int HSL_UNIT  = 65025;
	localparam int LEVEL_DEN = HSL_UNIT * SIXTH_DEG;
	localparam int L_HALF    = 127;

endpackage

`default_nettype wire

// ===== src/hslrgb_chan.sv =====
// hslrgb_chan: one output channel, from the two levels and the channel hue to the
// scaled channel value. Ramp select, reciprocal product, remainder, one-step fix-up.
// Depends on hslrgb_pkg.
`default_nettype none

module hslrgb_chan #(
	parameter int CHANNEL_BITS = hslrgb_pkg::CHANNEL_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic [hslrgb_pkg::CHAN_STAGES-1:0]  en,
	input  wire logic [hslrgb_pkg::LVL_W-1:0]        m1,
	input  wire logic [hslrgb_pkg::LVL_W-1:0]        m2,
	input  wire logic [hslrgb_pkg::HUE_W-1:0]        hue,
	output logic      [CHANNEL_BITS-1:0]             level
);

	localparam int NW = hslrgb_pkg::NUM_W;
	localparam int LW = hslrgb_pkg::LVL_W;
	localparam int HW = hslrgb_pkg::HUE_W;
	localparam int RW = hslrgb_pkg::RAMP_W;
	localparam int XW = NW + CHANNEL_BITS;
	localparam int PW = NW + CHANNEL_BITS + 1;

	// floor((2^CHANNEL_BITS - 1) * 2^NW / den); 2^NW exceeds every numerator, so the
	// estimate is low by at most one
	localparam longint unsigned TOP_CODE = (64'd1 << CHANNEL_BITS) - 64'd1;
	localparam longint unsigned RECIP    =
		(TOP_CODE << NW) / 64'(hslrgb_pkg::LEVEL_DEN);

	logic [LW-1:0] span;
	logic [LW-1:0] base;
	logic [RW-1:0] ramp;
	logic [NW-1:0] base60;
	logic [NW-1:0] num_s3;
	logic [PW-1:0] prod;
	logic [NW-1:0] num_s4;
	logic [CHANNEL_BITS-1:0] est_s4;
	logic [XW-1:0] num_top;
	logic [NW:0]   rem_w;
	logic [NW:0]   rem_s5;
	logic [CHANNEL_BITS-1:0] est_s5;
	logic [CHANNEL_BITS-1:0] level_s6;

	// ramp piece select: rising, high level, falling, low level
	always_comb begin
		span = m2 - m1;
		if (hue < HW'(hslrgb_pkg::SIXTH_DEG)) begin
			base = m1;
			ramp = hue[RW-1:0];
		end else if (hue < HW'(3 * hslrgb_pkg::SIXTH_DEG)) begin
			base = m2;
			ramp = '0;
		end else if (hue < HW'(4 * hslrgb_pkg::SIXTH_DEG)) begin
			base = m1;
			ramp = RW'(HW'(4 * hslrgb_pkg::SIXTH_DEG) - hue);
		end else begin
			base = m1;
			ramp = '0;
		end
		base60 = {base, 6'd0} - {4'd0, base, 2'd0};
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			num_s3 <= base60 + NW'(span) * NW'(ramp);
		end
	end

	assign prod = PW'(num_s3) * PW'(RECIP);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			num_s4 <= num_s3;
			est_s4 <= prod[NW +: CHANNEL_BITS];
		end
	end

	// remainder is below twice the denominator, so the low NW+1 bits carry it whole
	assign num_top = {num_s4, CHANNEL_BITS'(0)} - XW'(num_s4);
	assign rem_w   = num_top[NW:0] - (NW+1)'(est_s4) * (NW+1)'(hslrgb_pkg::LEVEL_DEN);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			rem_s5 <= rem_w;
			est_s5 <= est_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			level_s6 <= est_s5 +
				CHANNEL_BITS'(rem_s5 >= (NW+1)'(hslrgb_pkg::LEVEL_DEN));
		end
	end

	assign level = level_s6;

endmodule

`default_nettype wire

// ===== src/hsl_to_rgb_converter_top.sv =====
// hsl_to_rgb_converter_top: HSL to RGB converter, stream in and stream out.
// Depends on hslrgb_pkg and hslrgb_chan.
//
// One color per clock while m_tready allows it: an item may be accepted in every cycle
// that s_tready is high. Each result passes two stages for the hue wrap and the two
// levels, then four per channel for the ramp, a reciprocal product, the remainder and
// a one-step fix-up that scales each level to CHANNEL_BITS.
// Every stage holds its own valid bit and fills whenever it is empty or moving on, so
// input keeps flowing into empty stages while a finished result waits at the output.
// Hue values 360..511 wrap by 360. Results are truncated, never rounded.
`default_nettype none

module hsl_to_rgb_converter_top #(
	parameter int CHANNEL_BITS = hslrgb_pkg::CHANNEL_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// hue_degrees[8:0], saturation[16:9], lightness[24:17], zero fill
	input  wire logic [31:0]                         s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// red, green, blue, CHANNEL_BITS each from bit 0 up, zero fill to bytes
	output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]      m_tdata
);

	localparam int DEPTH   = 2 + hslrgb_pkg::CHAN_STAGES;
	localparam int TDATA_W = ((3 * CHANNEL_BITS + 7) / 8) * 8;
	localparam int HW      = hslrgb_pkg::HUE_W;
	localparam int SW      = hslrgb_pkg::SL_W;
	localparam int LW      = hslrgb_pkg::LVL_W;

	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0] adv;

	logic [HW-1:0] hue_in;
	logic [SW-1:0] sat_in;
	logic [SW-1:0] lit_in;
	logic [HW-1:0] hue_w;
	logic [HW:0]   hue_r_sum;
	logic [HW:0]   hue_b_sum;
	logic [HW-1:0] hue_r;
	logic [HW-1:0] hue_b;

	logic [HW-1:0] hue_r_s1, hue_g_s1, hue_b_s1;
	logic [SW-1:0] sat_s1, lit_s1;
	logic [LW-1:0] ls_s1;

	logic [LW-1:0] l255, s255;
	logic [LW:0]   m2_wide;
	logic [LW:0]   m1_wide;

	logic [HW-1:0] hue_r_s2, hue_g_s2, hue_b_s2;
	logic [LW-1:0] m1_s2, m2_s2;

	logic [CHANNEL_BITS-1:0] red, green, blue;

	// stage advance: a stage moves when it is empty or the next one moves
	assign adv[DEPTH-1] = !vld_q[DEPTH-1] || m_tready;
	for (genvar k = 0; k < DEPTH - 1; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < DEPTH; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = adv[0];
	assign m_tvalid = vld_q[DEPTH-1];

	// stage 1: hue wrap, channel hues, l*s
	always_comb begin
		hue_in    = s_tdata[8:0];
		sat_in    = s_tdata[16:9];
		lit_in    = s_tdata[24:17];
		hue_w     = (hue_in >= HW'(hslrgb_pkg::HUE_FULL)) ?
			hue_in - HW'(hslrgb_pkg::HUE_FULL) : hue_in;
		hue_r_sum = {1'b0, hue_w} + (HW+1)'(hslrgb_pkg::HUE_THIRD);
		hue_b_sum = {1'b0, hue_w} + (HW+1)'(hslrgb_pkg::HUE_FULL - hslrgb_pkg::HUE_THIRD);
		hue_r     = (hue_r_sum >= (HW+1)'(hslrgb_pkg::HUE_FULL)) ?
			HW'(hue_r_sum - (HW+1)'(hslrgb_pkg::HUE_FULL)) : hue_r_sum[HW-1:0];
		hue_b     = (hue_b_sum >= (HW+1)'(hslrgb_pkg::HUE_FULL)) ?
			HW'(hue_b_sum - (HW+1)'(hslrgb_pkg::HUE_FULL)) : hue_b_sum[HW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			hue_r_s1 <= hue_r;
			hue_g_s1 <= hue_w;
			hue_b_s1 <= hue_b;
			sat_s1   <= sat_in;
			lit_s1   <= lit_in;
			ls_s1    <= LW'(sat_in) * LW'(lit_in);
		end
	end

	// stage 2: high and low levels in units of 1/65025
	always_comb begin
		l255 = {lit_s1, 8'd0} - LW'(lit_s1);
		s255 = {sat_s1, 8'd0} - LW'(sat_s1);
		if (lit_s1 <= SW'(hslrgb_pkg::L_HALF)) begin
			m2_wide = (LW+1)'(l255) + (LW+1)'(ls_s1);
		end else begin
			m2_wide = (LW+1)'(l255) + (LW+1)'(s255) - (LW+1)'(ls_s1);
		end
		m1_wide = {l255, 1'b0} - m2_wide;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			hue_r_s2 <= hue_r_s1;
			hue_g_s2 <= hue_g_s1;
			hue_b_s2 <= hue_b_s1;
			m2_s2    <= m2_wide[LW-1:0];
			m1_s2    <= m1_wide[LW-1:0];
		end
	end

	hslrgb_chan #(.CHANNEL_BITS(CHANNEL_BITS)) u_red (
		.clk   (clk),
		.en    (adv[DEPTH-1:2]),
		.m1    (m1_s2),
		.m2    (m2_s2),
		.hue   (hue_r_s2),
		.level (red)
	);

	hslrgb_chan #(.CHANNEL_BITS(CHANNEL_BITS)) u_green (
		.clk   (clk),
		.en    (adv[DEPTH-1:2]),
		.m1    (m1_s2),
		.m2    (m2_s2),
		.hue   (hue_g_s2),
		.level (green)
	);

	hslrgb_chan #(.CHANNEL_BITS(CHANNEL_BITS)) u_blue (
		.clk   (clk),
		.en    (adv[DEPTH-1:2]),
		.m1    (m1_s2),
		.m2    (m2_s2),
		.hue   (hue_b_s2),
		.level (blue)
	);

	assign m_tdata = TDATA_W'({blue, green, red});

endmodule

`default_nettype wire
